/* src/hltfr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hltfr_pkg
// Types and constants of the header / length / tail frame receiver.
// ----------------------------------------------------------------------------
package hltfr_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 6;
    localparam int unsigned CFG_A_W = 2;

    localparam logic [BYTE_W-1:0] FRAME_OVERHEAD = 8'd4;

    localparam logic [BYTE_W-1:0] RST_FIRST_HDR  = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_SECOND_HDR = 8'h55;
    localparam logic [BYTE_W-1:0] RST_TAIL       = 8'hAA;

    localparam logic [CFG_A_W-1:0] CFG_FIRST_HDR  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_SECOND_HDR = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_TAIL       = 2'd2;

    localparam logic [BYTE_W-1:0] POS_HUNT = 8'd0;
    localparam logic [BYTE_W-1:0] POS_HDR1 = 8'd1;
    localparam logic [BYTE_W-1:0] POS_HDR2 = 8'd2;
    localparam logic [BYTE_W-1:0] POS_BODY = 8'd3;

    typedef struct packed {
        logic [BYTE_W-1:0] first_hdr;
        logic [BYTE_W-1:0] second_hdr;
        logic [BYTE_W-1:0] tail;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] wr_slot;
        logic [BYTE_W-1:0] wr_data;
        logic              done;
        logic [BYTE_W-1:0] count;
    } t_parse_evt;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_READ,
        ST_LOAD
    } t_rd_state;

endpackage
`default_nettype wire

/* src/hltfr_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hltfr_in_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface hltfr_in_if;
    logic                            valid;
    logic                            ready;
    logic [hltfr_pkg::BYTE_W-1:0]    rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

/* src/hltfr_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hltfr_out_if
// Payload result channel.
// ----------------------------------------------------------------------------
interface hltfr_out_if;
    logic                            valid;
    logic                            ready;
    logic [hltfr_pkg::BYTE_W-1:0]    payload_byte;
    logic [hltfr_pkg::IDX_W-1:0]     payload_index;
    logic [hltfr_pkg::IDX_W-1:0]     payload_count;
    logic                            last;

    modport source (output valid, output payload_byte, output payload_index,
                    output payload_count, output last, input ready);
    modport sink   (input valid, input payload_byte, input payload_index,
                    input payload_count, input last, output ready);
endinterface
`default_nettype wire

/* src/hltfr_cfg_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hltfr_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface hltfr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hltfr_pkg::CFG_A_W-1:0]   index;
    logic [hltfr_pkg::BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/hltfr_parse.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hltfr_parse
// Frame position tracker: header match, length check, body slot, tail match.
// ----------------------------------------------------------------------------
module hltfr_parse #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire hltfr_pkg::t_cfg               i_cfg,
    input  wire logic                          i_accept,
    input  wire logic [hltfr_pkg::BYTE_W-1:0]  i_byte,
    output hltfr_pkg::t_parse_evt              o_evt
);

    localparam logic [hltfr_pkg::BYTE_W-1:0] MAX_LEN = hltfr_pkg::BYTE_W'(MAX_FRAME);

    logic [hltfr_pkg::BYTE_W-1:0] r_pos, n_pos;
    logic [hltfr_pkg::BYTE_W-1:0] r_len, n_len;

    always_comb begin
        n_pos         = r_pos;
        n_len         = r_len;
        o_evt.wr_en   = 1'b0;
        o_evt.wr_slot = r_pos - hltfr_pkg::POS_BODY;
        o_evt.wr_data = i_byte;
        o_evt.done    = 1'b0;
        o_evt.count   = r_len - hltfr_pkg::FRAME_OVERHEAD;
        if (i_accept) begin
            case (r_pos)
                hltfr_pkg::POS_HUNT: begin
                    if (i_byte == i_cfg.first_hdr) begin
                        n_pos = hltfr_pkg::POS_HDR1;
                    end
                end
                hltfr_pkg::POS_HDR1: begin
                    n_pos = (i_byte == i_cfg.second_hdr) ? hltfr_pkg::POS_HDR2
                                                          : hltfr_pkg::POS_HUNT;
                end
                hltfr_pkg::POS_HDR2: begin
                    if (i_byte < hltfr_pkg::FRAME_OVERHEAD || i_byte > MAX_LEN) begin
                        n_pos = hltfr_pkg::POS_HUNT;
                    end else begin
                        n_len = i_byte;
                        n_pos = hltfr_pkg::POS_BODY;
                    end
                end
                default: begin
                    if (r_pos < r_len - 8'd1) begin
                        o_evt.wr_en = 1'b1;
                        n_pos       = r_pos + 8'd1;
                    end else if (i_byte == i_cfg.tail) begin
                        o_evt.done = 1'b1;
                        n_pos      = hltfr_pkg::POS_HUNT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= hltfr_pkg::POS_HUNT;
            r_len <= '0;
        end else begin
            r_pos <= n_pos;
            r_len <= n_len;
        end
    end

endmodule
`default_nettype wire

/* src/header_length_tail_frame_receiver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// header_length_tail_frame_receiver
// Deframes header / length / tail serial frames and plays out the payload.
// ----------------------------------------------------------------------------
// Bytes enter on i_rx, one item per accepted handshake. Registers are written
// on i_cfg (index 0 first header, 1 second header, 2 tail; others ignored).
// Body bytes go into a one-port-write, registered-read payload buffer of
// MAX_FRAME-4 entries. Receiving takes one byte per cycle while i_rx is ready.
// When the tail byte arrives, i_rx drops and the buffer is read back: each
// payload item takes a buffer read, then a load of the output register, and
// waits while o_frame is stalled. An empty frame gives a single
// item with last set. The output register holds an item until it is taken;
// once the final item of a run is loaded, i_rx is ready again, so the next
// frame's bytes flow while that item waits. After frame completion the first
// item passes the buffer read and the output load; an empty frame only the
// output load. After reset the block hunts for the first header byte with the
// registers at their reset values; the buffer needs no clear.
// ----------------------------------------------------------------------------
module header_length_tail_frame_receiver #(
    parameter int unsigned MAX_FRAME = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    hltfr_in_if.sink          i_rx,
    hltfr_cfg_if.sink         i_cfg,
    hltfr_out_if.source       o_frame
);

    localparam int unsigned DEPTH  = (MAX_FRAME > 4) ? MAX_FRAME - 4 : 1;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    hltfr_pkg::t_cfg       r_cfg;
    hltfr_pkg::t_parse_evt w_evt;
    hltfr_pkg::t_rd_state  r_state, n_state;

    logic [hltfr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [hltfr_pkg::BYTE_W-1:0] r_rd_data;
    logic [hltfr_pkg::BYTE_W-1:0] r_rd_idx;
    logic [hltfr_pkg::BYTE_W-1:0] r_count;

    logic                          r_out_valid;
    logic [hltfr_pkg::BYTE_W-1:0]  r_out_byte;
    logic [hltfr_pkg::IDX_W-1:0]   r_out_index;
    logic [hltfr_pkg::IDX_W-1:0]   r_out_count;
    logic                          r_out_last;

    logic w_accept;
    logic w_out_free;
    logic w_rd_en;
    logic w_load_empty;
    logic w_load_byte;
    logic w_is_last;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = (r_state == hltfr_pkg::ST_RECV);
    assign w_accept    = i_rx.valid && i_rx.ready;
    assign w_out_free  = !r_out_valid || o_frame.ready;
    assign w_is_last   = (r_rd_idx + 8'd1 == r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_hdr  <= hltfr_pkg::RST_FIRST_HDR;
            r_cfg.second_hdr <= hltfr_pkg::RST_SECOND_HDR;
            r_cfg.tail       <= hltfr_pkg::RST_TAIL;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                hltfr_pkg::CFG_FIRST_HDR:  r_cfg.first_hdr  <= i_cfg.data;
                hltfr_pkg::CFG_SECOND_HDR: r_cfg.second_hdr <= i_cfg.data;
                hltfr_pkg::CFG_TAIL:       r_cfg.tail       <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    hltfr_parse #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (w_accept),
        .i_byte   (i_rx.rx_byte),
        .o_evt    (w_evt)
    );

    // payload buffer
    always_ff @(posedge i_clk) begin
        if (w_evt.wr_en) begin
            mem[w_evt.wr_slot[ADDR_W-1:0]] <= w_evt.wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_rd_idx[ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            hltfr_pkg::ST_RECV: begin
                if (w_evt.done) begin
                    n_state = hltfr_pkg::ST_READ;
                end
            end
            hltfr_pkg::ST_READ: begin
                if (r_count == '0) begin
                    if (w_out_free) begin
                        n_state = hltfr_pkg::ST_RECV;
                    end
                end else begin
                    n_state = hltfr_pkg::ST_LOAD;
                end
            end
            hltfr_pkg::ST_LOAD: begin
                if (w_out_free) begin
                    n_state = w_is_last ? hltfr_pkg::ST_RECV : hltfr_pkg::ST_READ;
                end
            end
            default: n_state = hltfr_pkg::ST_RECV;
        endcase
    end

    always_comb begin
        w_rd_en      = 1'b0;
        w_load_empty = 1'b0;
        w_load_byte  = 1'b0;
        case (r_state)
            hltfr_pkg::ST_READ: begin
                w_rd_en      = (r_count != '0);
                w_load_empty = (r_count == '0) && w_out_free;
            end
            hltfr_pkg::ST_LOAD: begin
                w_load_byte = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hltfr_pkg::ST_RECV;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_empty || w_load_byte) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_evt.done) begin
            r_count  <= w_evt.count;
            r_rd_idx <= '0;
        end else if (w_load_byte) begin
            r_rd_idx <= r_rd_idx + 8'd1;
        end
        if (w_load_empty) begin
            r_out_byte  <= '0;
            r_out_index <= '0;
            r_out_count <= '0;
            r_out_last  <= 1'b1;
        end else if (w_load_byte) begin
            r_out_byte  <= r_rd_data;
            r_out_index <= r_rd_idx[hltfr_pkg::IDX_W-1:0];
            r_out_count <= r_count[hltfr_pkg::IDX_W-1:0];
            r_out_last  <= w_is_last;
        end
    end

    assign o_frame.valid         = r_out_valid;
    assign o_frame.payload_byte  = r_out_byte;
    assign o_frame.payload_index = r_out_index;
    assign o_frame.payload_count = r_out_count;
    assign o_frame.last          = r_out_last;

endmodule
`default_nettype wire
